### rtl/core/spl_pkg.sv
`default_nettype none
package spl_pkg;

	localparam int FRAC_BITS  = 16;
	localparam int SH         = 30 - FRAC_BITS;
	localparam int STEPS      = 30;
	localparam int MAX_GROUPS = 64;

	localparam logic signed [33:0] KINV_Q30    = 34'sd652032874;
	localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
	localparam logic signed [33:0] PI_Q30      = 34'sd3373259426;

	// pi constants rounded into the port format
	localparam logic signed [19:0] HALF_PI_P       = 20'sd102944;
	localparam logic signed [19:0] THREE_HALF_PI_P = 20'sd308831;
	localparam logic [18:0]        TWO_PI_P        = 19'd411775;

	typedef enum logic [1:0] {
		REG_SHIFT_UP      = 2'd0,
		REG_GROUP_COUNT   = 2'd1,
		REG_INVALID_LIMIT = 2'd2
	} cfg_reg_t;

	// per-item data that rides along the pipeline
	typedef struct packed {
		logic [23:0] r;
		logic [19:0] az;
		logic        first;
		logic        valid;
	} side_t;

	// vectoring and square-root lane of one stage
	typedef struct packed {
		logic signed [59:0] x;
		logic signed [59:0] y;
		logic signed [33:0] ang;
		logic [53:0]        rem;
		logic [53:0]        res;
		logic               zero;
		side_t              side;
	} lane_t;

	function automatic logic signed [33:0] atan_q30(input logic [4:0] i);
		logic signed [33:0] v;
		case (i)
			5'd0:    v = 34'sd843314857;
			5'd1:    v = 34'sd497837829;
			5'd2:    v = 34'sd263043837;
			5'd3:    v = 34'sd133525159;
			5'd4:    v = 34'sd67021687;
			5'd5:    v = 34'sd33543516;
			5'd6:    v = 34'sd16775851;
			5'd7:    v = 34'sd8388437;
			5'd8:    v = 34'sd4194283;
			5'd9:    v = 34'sd2097149;
			default: v = 34'sd1 <<< (5'd30 - i);
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

### rtl/core/spl_rotate.sv
`default_nettype none
module spl_rotate (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      en,
	input  wire logic                      in_valid,
	input  wire logic signed [17:0]        in_elev,
	input  wire spl_pkg::side_t            in_side,
	output logic                           out_valid,
	output logic signed [33:0]             out_x,
	output logic signed [33:0]             out_y,
	output spl_pkg::side_t                 out_side
);
	import spl_pkg::*;

	logic               v_s  [0:STEPS];
	logic signed [33:0] x_s  [0:STEPS];
	logic signed [33:0] y_s  [0:STEPS];
	logic signed [33:0] a_s  [0:STEPS];
	side_t              sd_s [0:STEPS];

	logic signed [33:0] a_in, a_fold;

	// fold the angle into [-pi/2, pi/2]
	always_comb begin
		a_in = {{2{in_elev[17]}}, in_elev, 14'd0};
		if (a_in > HALF_PI_Q30)
			a_fold = PI_Q30 - a_in;
		else if (a_in < -HALF_PI_Q30)
			a_fold = -PI_Q30 - a_in;
		else
			a_fold = a_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s[0] <= 1'b0;
		else if (en)
			v_s[0] <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0]  <= KINV_Q30;
			y_s[0]  <= '0;
			a_s[0]  <= a_fold;
			sd_s[0] <= in_side;
		end
	end

	for (genvar i = 0; i < STEPS; i++) begin : g_step
		logic signed [33:0] dx, dy, nx, ny, na;
		always_comb begin
			dx = y_s[i] >>> i;
			dy = x_s[i] >>> i;
			if (a_s[i] >= 0) begin
				nx = x_s[i] - dx;
				ny = y_s[i] + dy;
				na = a_s[i] - atan_q30(5'(i));
			end else begin
				nx = x_s[i] + dx;
				ny = y_s[i] - dy;
				na = a_s[i] + atan_q30(5'(i));
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				v_s[i+1] <= 1'b0;
			else if (en)
				v_s[i+1] <= v_s[i];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				x_s[i+1]  <= nx;
				y_s[i+1]  <= ny;
				a_s[i+1]  <= na;
				sd_s[i+1] <= sd_s[i];
			end
		end
	end

	assign out_valid = v_s[STEPS];
	assign out_x     = x_s[STEPS];
	assign out_y     = y_s[STEPS];
	assign out_side  = sd_s[STEPS];

endmodule
`default_nettype wire

### rtl/core/spherical_point_lift_and_bin.sv
`default_nettype none
// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  tdata: input_range, input_elevation, input_azimuth
//                                   tuser: first_half
// m_*       out  m_tvalid/m_tready  tdata: lifted_range .. in_window; tuser: point_valid
// cfg_*     in   cfg_valid/cfg_ready  cfg_index, cfg_data (always ready)
//
// One request per cycle while the output register is not stalled.
// The main parts are the two 30-step CORDIC pipelines, the 27-step square root
// running beside the second one, and the 7-step sector division.
// Reset clears every stage valid bit and loads the register defaults.
// The whole pipeline holds while the output register is full and not taken.
module spherical_point_lift_and_bin (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [63:0] s_tdata,   // [23:0] input_range, [41:24] input_elevation,
	                                    // [61:42] input_azimuth, [63:62] zero
	input  wire logic        s_tuser,   // [0] first_half
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [71:0]      m_tdata,   // [23:0] lifted_range, [41:24] lifted_elevation,
	                                    // [61:42] azimuth_out, [67:62] sector_index,
	                                    // [68] in_window, [71:69] zero
	output logic             m_tuser,   // [0] point_valid
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [18:0] cfg_data
);
	import spl_pkg::*;

	localparam int LN = STEPS;

	// ---------------- configuration ----------------
	logic [18:0] shift_up_q;
	logic [6:0]  group_count_q;
	logic [16:0] limit_q;
	logic [6:0]  n_eff;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_up_q    <= 19'd81631;
			group_count_q <= 7'd15;
			limit_q       <= 17'd0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_SHIFT_UP:      shift_up_q    <= cfg_data;
				REG_GROUP_COUNT:   group_count_q <= cfg_data[6:0];
				REG_INVALID_LIMIT: limit_q       <= cfg_data[16:0];
				default: ;
			endcase
		end
	end

	// clamp sector count into [1, MAX_GROUPS]
	always_comb begin
		if (group_count_q == 7'd0)
			n_eff = 7'd1;
		else if (group_count_q > 7'(MAX_GROUPS))
			n_eff = 7'(MAX_GROUPS);
		else
			n_eff = group_count_q;
	end

	// ---------------- global advance ----------------
	logic en;
	logic out_valid_q;
	assign en       = !out_valid_q || m_tready;
	assign s_tready = en;

	// ---------------- rotation: sin/cos of input elevation ----------------
	side_t              in_side, rot_side;
	logic               rot_valid;
	logic signed [33:0] rot_x, rot_y;

	assign in_side.r     = s_tdata[23:0];
	assign in_side.az    = s_tdata[61:42];
	assign in_side.first = s_tuser;
	assign in_side.valid = s_tdata[23:0] >= {7'd0, limit_q};

	spl_rotate u_rot (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (s_tvalid && s_tready),
		.in_elev   (s_tdata[41:24]),
		.in_side   (in_side),
		.out_valid (rot_valid),
		.out_x     (rot_x),
		.out_y     (rot_y),
		.out_side  (rot_side)
	);

	// ---------------- products r*|cos| and r*sin ----------------
	logic               mul_v_s1;
	logic signed [58:0] pxh_s1, pzs_s1;
	side_t              mul_sd_s1;
	logic signed [33:0] cx_abs;

	assign cx_abs = (rot_x < 0) ? -rot_x : rot_x;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			mul_v_s1 <= 1'b0;
		else if (en)
			mul_v_s1 <= rot_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pxh_s1    <= $signed({1'b0, rot_side.r}) * cx_abs;
			pzs_s1    <= $signed({1'b0, rot_side.r}) * rot_y;
			mul_sd_s1 <= rot_side;
		end
	end

	// ---------------- round, subtract the lift ----------------
	logic               z_v_s2;
	logic signed [25:0] xh_s2;
	logic signed [26:0] z_s2;
	side_t              z_sd_s2;
	logic signed [58:0] pxh_rnd, pzs_rnd;
	logic signed [25:0] zs_c;
	logic signed [26:0] z_c;

	always_comb begin
		pxh_rnd = pxh_s1 + (59'sd1 <<< 29);
		pzs_rnd = pzs_s1 + (59'sd1 <<< 29);
		zs_c    = pzs_rnd[55:30];
		z_c     = $signed({zs_c[25], zs_c}) - $signed({8'd0, shift_up_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			z_v_s2 <= 1'b0;
		else if (en)
			z_v_s2 <= mul_v_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			xh_s2   <= pxh_rnd[55:30];
			z_s2    <= z_c;
			z_sd_s2 <= mul_sd_s1;
		end
	end

	// ---------------- vectoring CORDIC beside square root ----------------
	// Lane stage 0 loads; stages 1..30 run the vectoring steps. On the same
	// stages: 0 squares, 1 sums, 2..28 take one root bit each, 29 rounds.
	lane_t       ln_s [0:LN];
	logic        ln_v_s [0:LN];
	lane_t       ln0;
	logic [25:0] az_abs;

	always_comb begin
		az_abs      = z_s2[26] ? 26'(-z_s2) : z_s2[25:0];
		ln0.x       = $signed({{4{xh_s2[25]}}, xh_s2, 30'd0});
		ln0.y       = $signed({{3{z_s2[26]}}, z_s2, 30'd0});
		ln0.ang     = '0;
		ln0.rem     = 54'(xh_s2[24:0] * xh_s2[24:0]);
		ln0.res     = 54'(az_abs * az_abs);
		ln0.zero    = (xh_s2 == 26'sd0) && (z_s2 == 27'sd0);
		ln0.side    = z_sd_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ln_v_s[0] <= 1'b0;
		else if (en)
			ln_v_s[0] <= z_v_s2;
	end

	always_ff @(posedge clk) begin
		if (en)
			ln_s[0] <= ln0;
	end

	for (genvar k = 1; k <= LN; k++) begin : g_lane
		lane_t       nx;
		logic [53:0] trial;
		logic [53:0] bitv;
		always_comb begin
			nx    = ln_s[k-1];
			bitv  = '0;
			trial = '0;
			// vectoring step k-1
			if (ln_s[k-1].y >= 0) begin
				nx.x   = ln_s[k-1].x + (ln_s[k-1].y >>> (k-1));
				nx.y   = ln_s[k-1].y - (ln_s[k-1].x >>> (k-1));
				nx.ang = ln_s[k-1].ang + atan_q30(5'(k-1));
			end else begin
				nx.x   = ln_s[k-1].x - (ln_s[k-1].y >>> (k-1));
				nx.y   = ln_s[k-1].y + (ln_s[k-1].x >>> (k-1));
				nx.ang = ln_s[k-1].ang - atan_q30(5'(k-1));
			end
			// square root part
			if (k == 1) begin
				nx.rem = ln_s[k-1].rem + ln_s[k-1].res;
				nx.res = '0;
			end else if (k <= 28) begin
				bitv  = 54'd1 << (2 * (28 - k));
				trial = ln_s[k-1].res + bitv;
				if (ln_s[k-1].rem >= trial) begin
					nx.rem = ln_s[k-1].rem - trial;
					nx.res = (ln_s[k-1].res >> 1) + bitv;
				end else begin
					nx.res = ln_s[k-1].res >> 1;
				end
			end else if (k == 29) begin
				trial = ln_s[k-1].res + 54'(ln_s[k-1].rem > ln_s[k-1].res);
				nx.res = (trial > 54'hFFFFFF) ? 54'hFFFFFF : trial;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				ln_v_s[k] <= 1'b0;
			else if (en)
				ln_v_s[k] <= ln_v_s[k-1];
		end

		always_ff @(posedge clk) begin
			if (en)
				ln_s[k] <= nx;
		end
	end

	// ---------------- elevation, camera angle, angle*N ----------------
	logic               e_v_s3;
	logic [23:0]        e_range_s3;
	logic signed [17:0] e_elev_s3;
	logic [25:0]        e_p_s3;
	logic [6:0]         e_n_s3;
	side_t              e_sd_s3;
	logic signed [33:0] ang_rnd;
	logic signed [19:0] el_r, el_c, cam;
	logic [18:0]        cam_c;
	lane_t              lf;

	always_comb begin
		lf      = ln_s[LN];
		ang_rnd = lf.ang + (34'sd1 <<< (SH - 1));
		el_r    = ang_rnd[33:14];
		if (el_r > HALF_PI_P)
			el_c = HALF_PI_P;
		else if (el_r < -HALF_PI_P)
			el_c = -HALF_PI_P;
		else
			el_c = el_r;
		if (!lf.side.valid || lf.zero)
			el_c = '0;
		cam   = lf.side.first ? THREE_HALF_PI_P + el_c : HALF_PI_P - el_c;
		cam_c = (cam < 0) ? 19'd0 : cam[18:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			e_v_s3 <= 1'b0;
		else if (en)
			e_v_s3 <= ln_v_s[LN];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			e_range_s3 <= lf.side.valid ? lf.res[23:0] : 24'd0;
			e_elev_s3  <= el_c[17:0];
			e_p_s3     <= 26'(cam_c * n_eff);
			e_n_s3     <= n_eff;
			e_sd_s3    <= lf.side;
		end
	end

	// ---------------- restoring division by 2pi, one quotient bit a stage ----
	logic        d_v_s   [0:7];
	logic [25:0] d_rem_s [0:7];
	logic [6:0]  d_q_s   [0:7];
	logic [23:0] d_rng_s [0:7];
	logic [17:0] d_el_s  [0:7];
	logic [6:0]  d_n_s   [0:7];
	side_t       d_sd_s  [0:7];

	always_comb begin
		d_v_s[0]   = e_v_s3;
		d_rem_s[0] = e_p_s3;
		d_q_s[0]   = '0;
		d_rng_s[0] = e_range_s3;
		d_el_s[0]  = e_elev_s3;
		d_n_s[0]   = e_n_s3;
		d_sd_s[0]  = e_sd_s3;
	end

	for (genvar b = 0; b < 7; b++) begin : g_div
		localparam int QB = 6 - b;
		logic [25:0] dv;
		logic        take;
		assign dv   = 26'(TWO_PI_P) << QB;
		assign take = d_rem_s[b] >= dv;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				d_v_s[b+1] <= 1'b0;
			else if (en)
				d_v_s[b+1] <= d_v_s[b];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				d_rem_s[b+1] <= take ? d_rem_s[b] - dv : d_rem_s[b];
				d_q_s[b+1]   <= d_q_s[b] | (7'(take) << QB);
				d_rng_s[b+1] <= d_rng_s[b];
				d_el_s[b+1]  <= d_el_s[b];
				d_n_s[b+1]   <= d_n_s[b];
				d_sd_s[b+1]  <= d_sd_s[b];
			end
		end
	end

	// ---------------- output register ----------------
	logic [5:0]  idx;
	logic        win;
	logic [71:0] out_data_q;
	logic        out_pv_q;

	always_comb begin
		// a full turn wraps to sector 0 and lies outside the window
		idx = (d_q_s[7] == d_n_s[7]) ? 6'd0 : d_q_s[7][5:0];
		win = (d_q_s[7] != d_n_s[7]) &&
		      (22'(d_rem_s[7][18:0] * 3'd5) < 22'(TWO_PI_P));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (en)
			out_valid_q <= d_v_s[7];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_data_q <= {3'd0, win, idx, d_sd_s[7].az, d_el_s[7], d_rng_s[7]};
			out_pv_q   <= d_sd_s[7].valid;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_pv_q;

`ifndef SYNTHESIS
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[41:0] == 42'd0)
		else $error("invalid point with nonzero range or elevation");

	a_sector_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> {1'b0, m_tdata[67:62]} < n_eff)
		else $error("sector index beyond sector count");

	a_elev_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(m_tdata[41:24]) <= 18'sd102944 &&
		              $signed(m_tdata[41:24]) >= -18'sd102944))
		else $error("elevation out of range");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && !$past(s_tready))
		else $error("stalled result changed or input taken during stall");
`endif

endmodule
`default_nettype wire

### bench/spherical_point_lift_and_bin_test.sv
`timescale 1ns / 1ps
module spherical_point_lift_and_bin_test;
	import spl_pkg::*;

	// one result item as it appears on the output stream
	typedef struct {
		logic [23:0] lifted_range;
		logic [17:0] lifted_elevation;
		logic [19:0] azimuth_out;
		logic [5:0]  sector_index;
		logic        in_window;
		logic        point_valid;
	} lifted_point_t;

	class lift_scoreboard;
		logic [18:0]   shift_up;
		logic [6:0]    group_count;
		logic [16:0]   invalid_limit;
		lifted_point_t pending[$];
		int            errors;
		longint        arctan[30];

		function void init();
			longint head[10] = '{843314857, 497837829, 263043837, 133525159, 67021687,
				33543516, 16775851, 8388437, 4194283, 2097149};
			shift_up      = 19'd81631;
			group_count   = 7'd15;
			invalid_limit = 17'd0;
			errors        = 0;
			for (int i = 0; i < 30; i++)
				arctan[i] = (i < 10) ? head[i] : (64'sd1 <<< (30 - i));
		endfunction

		function void write_reg(cfg_reg_t idx, logic [18:0] data);
			case (idx)
				REG_SHIFT_UP:      shift_up = data;
				REG_GROUP_COUNT:   group_count = data[6:0];
				REG_INVALID_LIMIT: invalid_limit = data[16:0];
				default: ;
			endcase
		endfunction

		// square root rounded to nearest
		function longint unsigned root_round(longint unsigned v);
			longint unsigned res, bits;
			res  = 0;
			bits = 64'd1 << 62;
			while (bits > v)
				bits >>= 2;
			while (bits != 0) begin
				if (v >= res + bits) begin
					v   -= res + bits;
					res  = (res >> 1) + bits;
				end else begin
					res >>= 1;
				end
				bits >>= 2;
			end
			if (v > res)
				res++;
			return res;
		endfunction

		function longint to_port(longint a);
			return (a + (64'sd1 <<< (SH - 1))) >>> SH;
		endfunction

		// lift one accepted point and queue the result it must produce
		function void note_point(logic [63:0] data, logic first);
			lifted_point_t p;
			longint rr, a, cx, cy, dx, dy, xh, zs, z, bx, by, ang, elev, cam, n, q, idx;
			longint two_pi, lim;
			longint unsigned v, rng;
			logic ok;
			rr   = data[23:0];
			a    = longint'($signed(data[41:24]));
			ok   = rr >= longint'(invalid_limit);
			rng  = 0;
			elev = 0;
			if (ok) begin
				a  = a * (64'sd1 <<< SH);
				// fold the angle into [-pi/2, pi/2]
				if (a > HALF_PI_Q30)
					a = PI_Q30 - a;
				else if (a < -HALF_PI_Q30)
					a = -PI_Q30 - a;
				cx = KINV_Q30;
				cy = 0;
				for (int i = 0; i < 30; i++) begin
					dx = cy >>> i;
					dy = cx >>> i;
					if (a >= 0) begin
						cx -= dx; cy += dy; a -= arctan[i];
					end else begin
						cx += dx; cy -= dy; a += arctan[i];
					end
				end
				if (cx < 0)
					cx = -cx;
				xh  = (rr * cx + (64'sd1 <<< 29)) >>> 30;
				zs  = (rr * cy + (64'sd1 <<< 29)) >>> 30;
				z   = zs - longint'(shift_up);
				v   = xh * xh + z * z;
				rng = root_round(v);
				if (rng > 64'hFFFFFF)
					rng = 64'hFFFFFF;
				if (v != 0) begin
					bx  = xh * (64'sd1 <<< 30);
					by  = z * (64'sd1 <<< 30);
					ang = 0;
					for (int i = 0; i < 30; i++) begin
						dx = by >>> i;
						dy = bx >>> i;
						if (by >= 0) begin
							bx += dx; by -= dy; ang += arctan[i];
						end else begin
							bx -= dx; by += dy; ang -= arctan[i];
						end
					end
					elev = to_port(ang);
					lim  = to_port(HALF_PI_Q30);
					if (elev > lim)
						elev = lim;
					if (elev < -lim)
						elev = -lim;
				end
			end
			// camera angle and sector
			two_pi = TWO_PI_P;
			cam    = first ? longint'(THREE_HALF_PI_P) + elev : longint'(HALF_PI_P) - elev;
			n      = group_count;
			if (n < 1)
				n = 1;
			if (n > MAX_GROUPS)
				n = MAX_GROUPS;
			if (cam < 0)
				cam = 0;
			q   = (cam * n) / two_pi;
			idx = q % n;
			p.lifted_range     = rng[23:0];
			p.lifted_elevation = elev[17:0];
			p.azimuth_out      = data[61:42];
			p.sector_index     = idx[5:0];
			p.in_window        = (cam * n * 5 < (5 * idx + 1) * two_pi);
			p.point_valid      = ok;
			pending.push_back(p);
		endfunction

		function void check_point(logic [71:0] data, logic user);
			lifted_point_t e;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result %h/%b", $time, data, user);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (data[23:0] !== e.lifted_range) begin
				$display("%0t: lifted_range exp %0d got %0d", $time, e.lifted_range,
					data[23:0]);
				errors++;
			end
			if (data[41:24] !== e.lifted_elevation) begin
				$display("%0t: lifted_elevation exp %0d got %0d", $time,
					$signed(e.lifted_elevation), $signed(data[41:24]));
				errors++;
			end
			if (data[61:42] !== e.azimuth_out) begin
				$display("%0t: azimuth_out exp %h got %h", $time, e.azimuth_out, data[61:42]);
				errors++;
			end
			if (data[67:62] !== e.sector_index) begin
				$display("%0t: sector_index exp %0d got %0d", $time, e.sector_index,
					data[67:62]);
				errors++;
			end
			if (data[68] !== e.in_window) begin
				$display("%0t: in_window exp %b got %b", $time, e.in_window, data[68]);
				errors++;
			end
			if (user !== e.point_valid) begin
				$display("%0t: point_valid exp %b got %b", $time, e.point_valid, user);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata = '0;    // [23:0] range, [41:24] elevation, [61:42] azimuth
	logic        s_tuser = 1'b0;  // [0] first_half
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [71:0] m_tdata;         // range, elevation, azimuth, sector, in_window
	logic        m_tuser;         // [0] point_valid
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [18:0] cfg_data = '0;

	lift_scoreboard points = new();
	bit             tx_idle = 1'b0;
	bit             rx_stall = 1'b0;
	int             idle_pct = 77;

	spherical_point_lift_and_bin dut (.*);

	always #5 clk = ~clk;

	// the run must end long before this even with the heaviest stalling
	initial begin
		#5ms;
		$display("Verification failed");
		$finish;
	end

	// receiver: stall at random only in the stalling phases
	always @(posedge clk)
		m_tready <= rx_stall ? ($urandom_range(0, 99) >= idle_pct) : 1'b1;

	// watch all three channels at each edge; values read here are pre-edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				points.write_reg(cfg_reg_t'(cfg_index), cfg_data);
			if (s_tvalid && s_tready)
				points.note_point(s_tdata, s_tuser);
			if (m_tvalid && m_tready)
				points.check_point(m_tdata, m_tuser);
		end
	end

	task automatic write_reg(cfg_reg_t idx, logic [18:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// offer one request, holding it until taken
	task automatic send_point(logic [23:0] r, logic [17:0] t, logic [19:0] az, logic first);
		while (tx_idle && $urandom_range(0, 99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {2'b00, az, t, r};
		s_tuser  <= first;
		do @(posedge clk); while (!s_tready);
	endtask

	// drop valid, wait for every result, then let the pipeline empty out
	task automatic drain();
		s_tvalid <= 1'b0;
		while (points.pending.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic directed_points();
		send_point(24'd0, 18'sd0, 20'sd0, 1'b1);            // zero range
		send_point(24'd0, 18'sd0, 20'sd0, 1'b0);
		send_point(24'hFFFFFF, 18'sd102944, 20'sd411775, 1'b1);
		send_point(24'hFFFFFF, -18'sd102944, -20'sd411775, 1'b0);
		send_point(24'd65536, 18'sd102944, 20'sd0, 1'b1);   // straight up: full turn with zero lift
		send_point(24'd65536, -18'sd102944, 20'sd0, 1'b0);
		send_point(24'd1, 18'sd131071, 20'h80000, 1'b1);    // beyond pi/2, folded
		send_point(24'd1000, 18'h20000, 20'h7FFFF, 1'b0);
		send_point(24'd81631, 18'sd0, 20'sd0, 1'b0);
		send_point(24'd65535, 18'sd51472, 20'sd12345, 1'b1);
		send_point(24'hFFFFFF, 18'sd0, 20'hFFFFF, 1'b1);
		send_point(24'd65536, -18'sd51472, 20'sd0, 1'b0);
	endtask

	task automatic random_points(int count);
		logic [23:0] r;
		logic [17:0] t;
		int          sel;
		for (int i = 0; i < count; i++) begin
			// step through the idling patterns every 30 requests
			if (i % 30 == 0) begin
				sel      = (i / 30) % 4;
				tx_idle  = sel[0];
				rx_stall = sel[1];
				idle_pct = (sel == 3) ? 8 : 77;
			end
			case ($urandom_range(0, 3))
				0:       r = 24'($urandom_range(0, 131072));
				1:       r = 24'($urandom_range(0, 24'hFFFFF));
				default: r = 24'($urandom);
			endcase
			if ($urandom_range(0, 9) == 0)
				t = 18'($urandom);
			else
				t = 18'(int'($urandom_range(0, 205888)) - 102944);
			send_point(r, t, 20'($urandom), 1'($urandom_range(0, 1)));
		end
	endtask

	initial begin
		logic [18:0] settings[6][3] = '{
			'{19'd81631, 19'd15, 19'd0},
			'{19'd0, 19'd1, 19'd0},
			'{19'd327680, 19'd64, 19'd65536},
			'{19'd40000, 19'd0, 19'd1000},
			'{19'd81631, 19'd127, 19'd32768},
			'{19'd0, 19'd0, 19'd0}};
		points.init();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		settings[5][0] = 19'($urandom_range(0, 327680));
		settings[5][1] = 19'($urandom_range(1, 64));
		settings[5][2] = 19'($urandom_range(0, 65536));
		for (int ph = 0; ph < 6; ph++) begin
			tx_idle  = 1'b0;
			rx_stall = 1'b0;
			if (ph > 0) begin
				write_reg(REG_SHIFT_UP, settings[ph][0]);
				write_reg(REG_GROUP_COUNT, settings[ph][1]);
				write_reg(REG_INVALID_LIMIT, settings[ph][2]);
			end
			if (ph < 2)
				directed_points();
			random_points(120);
			drain();
		end
		if (points.errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

### filelist.f
rtl/core/spl_pkg.sv
rtl/core/spl_rotate.sv
rtl/core/spherical_point_lift_and_bin.sv
bench/spherical_point_lift_and_bin_test.sv
